[rtl/assert_macros.svh]
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/ppsc_pkg.sv]
// ----------------------------------------------------------------------------
// ppsc_pkg: shared constants of the period and prescaler calculator
// Counter width, prescaler limit, channel width and divider sizing.
// ----------------------------------------------------------------------------
package ppsc_pkg;

  localparam int CNT_W        = 16;  // timer counter width
  localparam int PRE_W        = 3;   // prescaler code width
  localparam int CHAN_W       = 3;   // channel number width
  localparam int DIV_W        = 32;  // divider operand width
  localparam int DIV_CW       = $clog2(DIV_W);

  localparam logic [PRE_W-1:0] MAX_PRESCALE = 3'b111;
  localparam logic [CNT_W-1:0] CNT_MAX      = 16'hFFFF;

endpackage

[rtl/pwm_period_prescale_calc_unit.sv]
// ----------------------------------------------------------------------------
// pwm_period_prescale_calc_unit: timer period and prescaler calculator
// Write the timer input clock in hertz through cfg_we/cfg_wdata while idle.
// Pulse start with busy low to launch a transaction carrying target frequency,
// old period, channel match and channel number. busy stays high until the
// result has been shown. One result follows each transaction: out_valid is
// high for exactly one cycle with all out_ fields; the receiver cannot stall,
// so take it in that cycle. A transaction runs 32 steps of the shared radix-2
// divider for clock/freq, one decrement, the prescaler shifter, one multiply
// and 32 divider steps for the match rescale. A divide error skips the
// rescale. out_valid holds for one cycle, the block drops back to idle at the
// edge that ends it, and only then accepts the next transaction, so a new
// transaction cannot start before the last result has been shown. Reset
// (rst_n low, synchronous) clears the clock register to zero and drops any
// transaction in progress.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pwm_period_prescale_calc_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [31:0]                   cfg_wdata,
  // input channel
  input  logic                          start,
  output logic                          busy,
  input  logic [31:0]                   in_target_freq,
  input  logic [ppsc_pkg::CNT_W-1:0]    in_old_period,
  input  logic [ppsc_pkg::CNT_W-1:0]    in_channel_match,
  input  logic [ppsc_pkg::CHAN_W-1:0]   in_channel_number,
  // result channel
  output logic                          out_valid,
  output logic [ppsc_pkg::CNT_W-1:0]    out_new_period,
  output logic [ppsc_pkg::PRE_W-1:0]    out_prescale_shift,
  output logic [ppsc_pkg::CNT_W-1:0]    out_new_match,
  output logic [ppsc_pkg::CHAN_W-1:0]   out_channel,
  output logic                          out_period_saturated,
  output logic                          out_match_clamped,
  output logic                          out_divide_error
);
  import ppsc_pkg::*;

  // Sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV1  = 3'd1;  // clock_hz / target_freq
  localparam logic [2:0] ST_DEC   = 3'd2;  // quotient minus one
  localparam logic [2:0] ST_SHIFT = 3'd3;  // halve period, raise prescaler
  localparam logic [2:0] ST_MUL   = 3'd4;  // match * period
  localparam logic [2:0] ST_DIV2  = 3'd5;  // product / old_period
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [DIV_CW-1:0] LAST_STEP = DIV_CW'(DIV_W - 1);

  logic [2:0]        state_r, state_nxt;
  logic [31:0]       clock_hz_r;

  // captured transaction
  logic [CNT_W-1:0]  oldp_r, oldp_nxt;
  logic [CNT_W-1:0]  match_r, match_nxt;
  logic [CHAN_W-1:0] chan_r, chan_nxt;
  logic              derr_r, derr_nxt;

  // shared divider
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  dvs_r, dvs_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;

  // period and prescaler
  logic [31:0]       per_r, per_nxt;
  logic [PRE_W-1:0]  pre_r, pre_nxt;
  logic              sat_r, sat_nxt;

  logic [DIV_W:0]    step_sh;
  logic [DIV_W:0]    step_diff;
  logic [DIV_W-1:0]  step_rem;
  logic [DIV_W-1:0]  step_quo;
  logic [31:0]       prod;
  logic              match_over;

  // One restoring division step: shift in the next dividend bit, try subtract.
  always_comb begin
    step_sh   = {rem_r, quo_r[DIV_W-1]};
    step_diff = step_sh - {1'b0, dvs_r};
    if (!step_diff[DIV_W]) begin
      step_rem = step_diff[DIV_W-1:0];
      step_quo = {quo_r[DIV_W-2:0], 1'b1};
    end else begin
      step_rem = step_sh[DIV_W-1:0];
      step_quo = {quo_r[DIV_W-2:0], 1'b0};
    end
  end

  assign prod = {16'b0, match_r} * {16'b0, per_r[CNT_W-1:0]};

  always_comb begin
    state_nxt = state_r;
    oldp_nxt  = oldp_r;
    match_nxt = match_r;
    chan_nxt  = chan_r;
    derr_nxt  = derr_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dvs_nxt   = dvs_r;
    cnt_nxt   = cnt_r;
    per_nxt   = per_r;
    pre_nxt   = pre_r;
    sat_nxt   = sat_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          // A zero divisor yields an all-ones quotient from the divider itself.
          oldp_nxt  = in_old_period;
          match_nxt = in_channel_match;
          chan_nxt  = in_channel_number;
          derr_nxt  = (in_target_freq == 32'd0) || (in_old_period == '0);
          rem_nxt   = '0;
          quo_nxt   = clock_hz_r;
          dvs_nxt   = in_target_freq;
          cnt_nxt   = '0;
          pre_nxt   = '0;
          sat_nxt   = 1'b0;
          state_nxt = ST_DIV1;
        end
      end
      ST_DIV1: begin
        rem_nxt = step_rem;
        quo_nxt = step_quo;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        // wraps to all ones when the quotient is zero
        per_nxt   = quo_r - 32'd1;
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (per_r[31:CNT_W] != '0) begin
          if (pre_r == MAX_PRESCALE) begin
            per_nxt   = {{(32-CNT_W){1'b0}}, CNT_MAX};
            sat_nxt   = 1'b1;
            state_nxt = ST_MUL;
          end else begin
            per_nxt = {1'b0, per_r[31:1]};
            pre_nxt = pre_r + 1'b1;
          end
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (derr_r) begin
          state_nxt = ST_DONE;
        end else begin
          rem_nxt   = '0;
          quo_nxt   = prod;
          dvs_nxt   = {{(DIV_W-CNT_W){1'b0}}, oldp_r};
          cnt_nxt   = '0;
          state_nxt = ST_DIV2;
        end
      end
      ST_DIV2: begin
        rem_nxt = step_rem;
        quo_nxt = step_quo;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      clock_hz_r <= 32'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        clock_hz_r <= cfg_wdata;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    oldp_r  <= oldp_nxt;
    match_r <= match_nxt;
    chan_r  <= chan_nxt;
    derr_r  <= derr_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dvs_r   <= dvs_nxt;
    cnt_r   <= cnt_nxt;
    per_r   <= per_nxt;
    pre_r   <= pre_nxt;
    sat_r   <= sat_nxt;
  end

  // Clamp the rescaled match to the counter range; drop it on a divide error.
  assign match_over = (quo_r[DIV_W-1:CNT_W] != '0);

  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = (state_r == ST_DONE);
  assign out_new_period       = per_r[CNT_W-1:0];
  assign out_prescale_shift   = pre_r;
  assign out_new_match        = derr_r ? '0 : (match_over ? CNT_MAX : quo_r[CNT_W-1:0]);
  assign out_channel          = chan_r;
  assign out_period_saturated = sat_r;
  assign out_match_clamped    = !derr_r && match_over;
  assign out_divide_error     = derr_r;

  // Assertions
  `ASSERT_CLK(a_strobe_single, clk, rst_n, out_valid |=> !out_valid,
              "out_valid held over one cycle")
  `ASSERT_CLK(a_start_busy, clk, rst_n, (start && !busy) |=> busy,
              "accepted transaction not marked busy")
  `ASSERT_CLK(a_sat_max, clk, rst_n,
              (out_valid && out_period_saturated) |->
                ((out_new_period == CNT_MAX) && (out_prescale_shift == MAX_PRESCALE)),
              "saturated period not at maximum")
  `ASSERT_CLK(a_derr_match, clk, rst_n,
              (out_valid && out_divide_error) |->
                ((out_new_match == '0) && !out_match_clamped),
              "match not cleared on divide error")

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the timer period and prescaler calculator
// Drives start/busy transactions and writes to the clock register between
// phases. A monitor predicts each period, prescaler and rescaled match as a
// transaction is accepted. It compares every out_valid strobe against the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import ppsc_pkg::*;

  // Stop the run here if the block hangs. The limit sits well above the slowest
  // legal run of about 1250 transactions with their longest idle gaps.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 100;  // a little above the worst latency
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned MAX_REPORTS = 40;

  typedef struct packed {
    logic [31:0]       target_freq;
    logic [CNT_W-1:0]  old_period;
    logic [CNT_W-1:0]  channel_match;
    logic [CHAN_W-1:0] channel_number;
  } timer_req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  new_period;
    logic [PRE_W-1:0]  prescale_shift;
    logic [CNT_W-1:0]  new_match;
    logic [CHAN_W-1:0] channel;
    logic              period_saturated;
    logic              match_clamped;
    logic              divide_error;
  } timer_setting_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [31:0]       cfg_wdata;
  logic              start;
  logic              busy;
  logic [31:0]       in_target_freq;
  logic [CNT_W-1:0]  in_old_period;
  logic [CNT_W-1:0]  in_channel_match;
  logic [CHAN_W-1:0] in_channel_number;
  logic              out_valid;
  logic [CNT_W-1:0]  out_new_period;
  logic [PRE_W-1:0]  out_prescale_shift;
  logic [CNT_W-1:0]  out_new_match;
  logic [CHAN_W-1:0] out_channel;
  logic              out_period_saturated;
  logic              out_match_clamped;
  logic              out_divide_error;

  // Settings still owed by the block, oldest first.
  timer_setting_t pending_settings[$];
  logic [31:0]    clock_hz_model;

  int unsigned failures;
  int unsigned cycle_count;
  int unsigned transactions_accepted;
  int unsigned results_checked;
  int unsigned clock_writes;
  int unsigned saturated_seen;
  int unsigned clamped_seen;
  int unsigned div_error_seen;
  bit          quiet_stretch;

  pwm_period_prescale_calc_unit DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .start                (start),
    .busy                 (busy),
    .in_target_freq       (in_target_freq),
    .in_old_period        (in_old_period),
    .in_channel_match     (in_channel_match),
    .in_channel_number    (in_channel_number),
    .out_valid            (out_valid),
    .out_new_period       (out_new_period),
    .out_prescale_shift   (out_prescale_shift),
    .out_new_match        (out_new_match),
    .out_channel          (out_channel),
    .out_period_saturated (out_period_saturated),
    .out_match_clamped    (out_match_clamped),
    .out_divide_error     (out_divide_error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Period is clock/freq - 1, wrapping in 32 bits. Halve it until it fits the
  // counter, and force the maximum once the prescaler would pass its limit.
  // Rescale the match to the new period unless a divisor is zero.
  function automatic timer_setting_t predict_timer_setting(input logic [31:0] clock_hz,
                                                           input timer_req_t req);
    timer_setting_t res;
    logic [31:0]    quotient;
    logic [31:0]    period;
    logic [31:0]    product;
    logic [31:0]    scaled;
    int unsigned    shift;
    res = '0;
    quotient = (req.target_freq != 32'd0) ? clock_hz / req.target_freq : 32'hFFFF_FFFF;
    period = quotient - 32'd1;
    shift = 0;
    while (period > {16'd0, CNT_MAX}) begin
      period = period >> 1;
      shift++;
      if (shift > MAX_PRESCALE) begin
        period = {16'd0, CNT_MAX};
        shift = MAX_PRESCALE;
        res.period_saturated = 1'b1;
        break;
      end
    end
    res.new_period = period[CNT_W-1:0];
    res.prescale_shift = shift[PRE_W-1:0];
    res.channel = req.channel_number;
    res.divide_error = (req.target_freq == 32'd0) || (req.old_period == '0);
    if (!res.divide_error) begin
      product = {16'd0, req.channel_match} * {16'd0, period[CNT_W-1:0]};
      scaled = product / {16'd0, req.old_period};
      if (scaled > {16'd0, CNT_MAX}) begin
        res.new_match = CNT_MAX;
        res.match_clamped = 1'b1;
      end else begin
        res.new_match = scaled[CNT_W-1:0];
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: check strobed results, then record accepted transactions
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      if (failures < MAX_REPORTS)
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  // A result can never belong to the transaction accepted at the same edge,
  // so check before recording. Track the clock register after both.
  always @(posedge clk) begin : result_check
    timer_setting_t want;
    timer_req_t     req;
    if (!rst_n) begin
      clock_hz_model = '0;
      pending_settings.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        if (pending_settings.size() == 0) begin
          if (failures < MAX_REPORTS)
            $error("result strobe with no transaction outstanding");
          failures++;
        end else begin
          want = pending_settings.pop_front();
          check_field("new_period", want.new_period, out_new_period);
          check_field("prescale_shift", want.prescale_shift, out_prescale_shift);
          check_field("new_match", want.new_match, out_new_match);
          check_field("out_channel", want.channel, out_channel);
          check_field("period_saturated", want.period_saturated, out_period_saturated);
          check_field("match_clamped", want.match_clamped, out_match_clamped);
          check_field("divide_error", want.divide_error, out_divide_error);
          results_checked++;
          saturated_seen += want.period_saturated;
          clamped_seen += want.match_clamped;
          div_error_seen += want.divide_error;
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        req = '{in_target_freq, in_old_period, in_channel_match, in_channel_number};
        pending_settings.push_back(predict_timer_setting(clock_hz_model, req));
        transactions_accepted++;
      end
      if (cfg_we === 1'b1)
        clock_hz_model = cfg_wdata;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
               pending_settings.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Mostly back-to-back, some short pauses, now and then a long one that can
  // outlast the block's whole computation.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (quiet_stretch || roll < 12)
      return 0;
    if (roll < 18)
      return $urandom_range(1, 4);
    return $urandom_range(5, 120);
  endfunction

  // Hold start low for the gap, then present the transaction and wait for it
  // to be taken. Leave start high, so a following transaction needs no
  // second assignment in the same step.
  task automatic send_request(input timer_req_t req);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start             <= 1'b1;
    in_target_freq    <= req.target_freq;
    in_old_period     <= req.old_period;
    in_channel_match  <= req.channel_match;
    in_channel_number <= req.channel_number;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
  endtask

  // Write the clock register only once the block has gone quiet.
  task automatic write_clock_hz(input logic [31:0] hz);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= hz;
    @(negedge clk);
    cfg_we    <= 1'b0;
    clock_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // The clock register resets to zero, so every period saturates.
  task automatic test_clock_disabled();
    send_request('{32'd1000, 16'd100, 16'd50, 3'd0});
    send_request('{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 3'd7});
  endtask

  task automatic test_divide_errors();
    write_clock_hz(32'd48_000_000);
    send_request('{32'd0, 16'd100, 16'd40, 3'd1});
    send_request('{32'd1000, 16'd0, 16'hFFFF, 3'd2});
    send_request('{32'd0, 16'd0, 16'd0, 3'd3});
  endtask

  // Step the frequency by powers of two so each prescaler code is hit, then
  // one step past the limit.
  task automatic test_prescaler_range();
    write_clock_hz(32'hFFFF_FFFF);
    for (int k = 0; k <= 8; k++)
      send_request('{32'd1 << (16 - k), 16'h8000, 16'h4000, k[CHAN_W-1:0]});
  endtask

  task automatic test_clock_below_target();
    write_clock_hz(32'd1000);
    send_request('{32'd1001, 16'd10, 16'd5, 3'd4});
    send_request('{32'hFFFF_FFFF, 16'd10, 16'd5, 3'd5});
    send_request('{32'd1000, 16'd10, 16'd5, 3'd6});
    write_clock_hz(32'd1);
    send_request('{32'd1, 16'd1, 16'hFFFF, 3'd7});
  endtask

  task automatic test_match_clamp();
    write_clock_hz(32'hFFFF_FFFF);
    send_request('{32'd65536, 16'd1, 16'hFFFF, 3'd0});
    send_request('{32'd65536, 16'hFFFF, 16'd0, 3'd1});
    send_request('{32'd65536, 16'hFFFF, 16'hFFFF, 3'd2});
  endtask

  // Aim most frequencies at a quotient across the prescaler bands; mix in
  // zeros, full-range values and very low frequencies.
  function automatic logic [31:0] pick_freq(input logic [31:0] clock_hz);
    int unsigned roll;
    logic [31:0] quotient;
    roll = $urandom_range(0, 99);
    if (roll < 5)
      return 32'd0;
    if (roll < 25)
      return $urandom;
    if (roll < 35)
      return $urandom_range(1, 1000);
    quotient = $urandom_range(1, 32'hFFFF) << $urandom_range(0, 9);
    if (clock_hz / quotient == 0)
      return $urandom_range(1, 4);
    return clock_hz / quotient;
  endfunction

  function automatic timer_req_t pick_request(input logic [31:0] clock_hz);
    timer_req_t req;
    int unsigned roll;
    req.target_freq = pick_freq(clock_hz);
    roll = $urandom_range(0, 99);
    if (roll < 4)
      req.old_period = '0;
    else if (roll < 25)
      req.old_period = $urandom_range(1, 16);
    else
      req.old_period = $urandom_range(0, 32'hFFFF);
    roll = $urandom_range(0, 99);
    if (roll < 5)
      req.channel_match = '0;
    else if (roll < 10)
      req.channel_match = CNT_MAX;
    else
      req.channel_match = $urandom_range(0, 32'hFFFF);
    req.channel_number = $urandom_range(0, 7);
    return req;
  endfunction

  task automatic test_random_traffic();
    logic [31:0] phase_clocks[6];
    phase_clocks = '{$urandom, 32'd48_000_000, 32'hFFFF_FFFF, 32'd32_768,
                     $urandom_range(1, 255), $urandom};
    foreach (phase_clocks[p]) begin
      write_clock_hz(phase_clocks[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Switch idle gaps off for whole stretches now and then.
        if (n % 50 == 0)
          quiet_stretch = ($urandom_range(0, 3) == 0);
        send_request(pick_request(phase_clocks[p]));
      end
      quiet_stretch = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    start             <= 1'b0;
    in_target_freq    <= '0;
    in_old_period     <= '0;
    in_channel_match  <= '0;
    in_channel_number <= '0;
    failures = 0;
    cycle_count = 0;
    transactions_accepted = 0;
    results_checked = 0;
    clock_writes = 0;
    saturated_seen = 0;
    clamped_seen = 0;
    div_error_seen = 0;
    quiet_stretch = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_clock_disabled();
    test_divide_errors();
    test_prescaler_range();
    test_clock_below_target();
    test_match_clamp();
    test_random_traffic();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d of %0d transactions over %0d clock register writes",
             results_checked, transactions_accepted, clock_writes);
    $display("Saturated periods %0d, clamped matches %0d, divide errors %0d",
             saturated_seen, clamped_seen, div_error_seen);
    if (failures == 0 && pending_settings.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
